// ===== design/deq_pkg.sv =====
// Package for the circular deque: storage sizes, request codes and the
// packed transaction types. Depends on nothing.

package deq_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_W  = 11;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_QUERY      = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  typedef struct packed {
    logic              we;
    idx_t              waddr;
    logic [DATA_W-1:0] wdata;
    idx_t              raddr_f;
    idx_t              raddr_r;
  } mem_cmd_t;

  typedef struct packed {
    logic ok;
    logic is_empty;
    logic is_full;
  } deq_stat_t;

endpackage

// ===== design/deq_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports,
// read-before-write on a shared address. Depends on nothing.

module deq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/deq_core.sv =====
// Index and flag update for the deque: front, rear, empty and capacity.
// Depends on deq_pkg; drives the RAM command and the result status.

module deq_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  deq_pkg::in_item_t         item,
  input  logic                      cfg_we,
  input  logic [deq_pkg::CAP_W-1:0] cfg_wdata,
  output deq_pkg::mem_cmd_t         cmd,
  output deq_pkg::deq_stat_t        stat
);
  import deq_pkg::*;

  idx_t front_r, front_nxt;
  idx_t rear_r, rear_nxt;
  logic empty_r, empty_nxt;
  idx_t cap_m1_r, cap_m1_nxt;

  idx_t f0, r0, f_inc, f_dec, r_inc, r_dec, r_n_inc;
  logic full0;
  logic [31:0] cfg_ext;

  always_comb begin
    cfg_ext = {{(32-CAP_W){1'b0}}, cfg_wdata};
    if (cfg_ext > 32'(DEPTH)) begin
      cap_m1_nxt = IDX_W'(DEPTH - 1);
    end else if (cfg_ext == 32'd0) begin
      cap_m1_nxt = '0;
    end else begin
      cap_m1_nxt = IDX_W'(cfg_ext - 32'd1);
    end
  end

  always_comb begin
    f0    = (front_r > cap_m1_r) ? '0 : front_r;
    r0    = (rear_r > cap_m1_r) ? '0 : rear_r;
    f_inc = (f0 == cap_m1_r) ? '0 : f0 + 1'b1;
    f_dec = (f0 == '0) ? cap_m1_r : f0 - 1'b1;
    r_inc = (r0 == cap_m1_r) ? '0 : r0 + 1'b1;
    r_dec = (r0 == '0) ? cap_m1_r : r0 - 1'b1;
    full0 = !empty_r && (r_inc == f0);

    front_nxt  = f0;
    rear_nxt   = r0;
    empty_nxt  = empty_r;
    stat.ok    = 1'b1;
    cmd.we     = 1'b0;
    cmd.waddr  = '0;
    cmd.wdata  = item.value;

    case (item.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full0) begin
          stat.ok = 1'b0;
        end else if (empty_r) begin
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
          cmd.we    = 1'b1;
          cmd.waddr = '0;
        end else if (item.req_type == REQ_PUSH_FRONT) begin
          front_nxt = f_dec;
          cmd.we    = 1'b1;
          cmd.waddr = f_dec;
        end else begin
          rear_nxt  = r_inc;
          cmd.we    = 1'b1;
          cmd.waddr = r_inc;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty_r) begin
          stat.ok = 1'b0;
        end else if (f0 == r0) begin
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b1;
        end else if (item.req_type == REQ_POP_FRONT) begin
          front_nxt = f_inc;
        end else begin
          rear_nxt = r_dec;
        end
      end
      default: begin
      end
    endcase

    cmd.we        = cmd.we & accept;
    cmd.raddr_f   = front_nxt;
    cmd.raddr_r   = rear_nxt;
    r_n_inc       = (rear_nxt == cap_m1_r) ? '0 : rear_nxt + 1'b1;
    stat.is_empty = empty_nxt;
    stat.is_full  = !empty_nxt && (r_n_inc == front_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      empty_r  <= 1'b1;
      cap_m1_r <= IDX_W'(DEPTH - 1);
    end else if (cfg_we) begin
      front_r  <= '0;
      rear_r   <= '0;
      empty_r  <= 1'b1;
      cap_m1_r <= cap_m1_nxt;
    end else if (accept) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

// ===== design/circular_deque_ring_buffer.sv =====
// Top level of the circular deque: index core, entry RAM and result stage.
// Depends on deq_pkg, deq_core and deq_ram.
//
//   channel   ports                       transfer
//   request   start, busy, in_data        start high and busy low at the edge
//   result    out_valid, out_data         one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_wdata           cfg_we high at the edge
//
// A request is taken in any cycle; its result strobes in the next cycle.
// The cycle of acceptance updates the indices, writes a pushed value and
// reads the new front and rear entries from the RAM's two read ports.
// The pushed value is forwarded when it lands on a slot read that cycle.
// busy stays low: one transaction per cycle. Reset empties the deque and
// sets capacity to the full storage depth; the RAM contents are not cleared.

module circular_deque_ring_buffer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  deq_pkg::in_item_t         in_data,
  output logic                      out_valid,
  output deq_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [deq_pkg::CAP_W-1:0] cfg_wdata
);
  import deq_pkg::*;

  logic              accept;
  mem_cmd_t          cmd;
  deq_stat_t         stat;
  deq_stat_t         stat_r;
  logic              out_valid_r;
  logic              fwd_f_r, fwd_r_r;
  logic [DATA_W-1:0] wdata_r;
  logic [DATA_W-1:0] rd_f, rd_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  deq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.we),
    .waddr   (cmd.waddr),
    .wdata   (cmd.wdata),
    .raddr_a (cmd.raddr_f),
    .raddr_b (cmd.raddr_r),
    .rdata_a (rd_f),
    .rdata_b (rd_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stat_r  <= stat;
    wdata_r <= cmd.wdata;
    fwd_f_r <= cmd.we && (cmd.waddr == cmd.raddr_f);
    fwd_r_r <= cmd.we && (cmd.waddr == cmd.raddr_r);
  end

  always_comb begin
    out_valid            = out_valid_r;
    out_data.ok          = stat_r.ok;
    out_data.is_empty    = stat_r.is_empty;
    out_data.is_full     = stat_r.is_full;
    out_data.front_value = stat_r.is_empty ? '1 : (fwd_f_r ? wdata_r : rd_f);
    out_data.rear_value  = stat_r.is_empty ? '1 : (fwd_r_r ? wdata_r : rd_r);
  end

endmodule

// ===== design/deq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
// Depends on deq_pkg and circular_deque_ring_buffer.

module deq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input deq_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input deq_pkg::out_item_t        out_data,
  input logic                      cfg_we,
  input logic [deq_pkg::CAP_W-1:0] cfg_wdata
);
  import deq_pkg::*;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("transaction accepted without a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted transaction");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |->
      (out_data.front_value == -32'sd1 && out_data.rear_value == -32'sd1 &&
       !out_data.is_full))
    else $error("empty deque shows entries or full");

  a_fail_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |->
      (out_data.is_empty || out_data.is_full) &&
      ($past(in_data.req_type) == REQ_PUSH_FRONT ||
       $past(in_data.req_type) == REQ_PUSH_BACK ||
       $past(in_data.req_type) == REQ_POP_FRONT ||
       $past(in_data.req_type) == REQ_POP_BACK))
    else $error("failure neither on full push nor on empty pop");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> (!(start && !busy) && !out_valid && !$isunknown(cfg_wdata)))
    else $error("capacity written with a transaction in flight");

endmodule

bind circular_deque_ring_buffer deq_checker u_deq_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for circular_deque_ring_buffer: directed and random
// requests against a behavioural deque kept alongside the block.
// Depends on deq_pkg and the circular_deque_ring_buffer RTL.
`timescale 1ns / 100ps

module tb;
  import deq_pkg::*;

  localparam logic [2:0] REQ_CODE_MAX = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 3;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  // deque mirror
  logic [DATA_W-1:0] slot_store [0:DEPTH-1];
  int unsigned front_idx;
  int unsigned rear_idx;
  bit deque_empty;
  logic [CAP_W-1:0] cap_setting;

  out_item_t pending_results [$];
  int unsigned err_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned cap_writes;
  int unsigned idle_pct;

  circular_deque_ring_buffer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned used_capacity();
    if (cap_setting == '0) return 1;
    if (cap_setting > DEPTH) return DEPTH;
    return 32'(cap_setting);
  endfunction

  function automatic bit ring_full(input int unsigned cap);
    int unsigned nxt;
    if (deque_empty) return 1'b0;
    nxt = rear_idx + 1;
    if (nxt >= cap) nxt = 0;
    return nxt == front_idx;
  endfunction

  function automatic out_item_t apply_request(input in_item_t rq);
    int unsigned cap;
    out_item_t res;
    logic done_ok;
    cap = used_capacity();
    done_ok = 1'b1;
    if (front_idx >= cap) front_idx = 0;
    if (rear_idx >= cap) rear_idx = 0;
    case (rq.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (ring_full(cap)) begin
          done_ok = 1'b0;
        end else if (deque_empty) begin
          front_idx = 0;
          rear_idx = 0;
          slot_store[0] = rq.value;
          deque_empty = 1'b0;
        end else if (rq.req_type == REQ_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? cap - 1 : front_idx - 1;
          slot_store[IDX_W'(front_idx)] = rq.value;
        end else begin
          rear_idx = (rear_idx + 1 >= cap) ? 0 : rear_idx + 1;
          slot_store[IDX_W'(rear_idx)] = rq.value;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (deque_empty) begin
          done_ok = 1'b0;
        end else if (front_idx == rear_idx) begin
          front_idx = 0;
          rear_idx = 0;
          deque_empty = 1'b1;
        end else if (rq.req_type == REQ_POP_FRONT) begin
          front_idx = (front_idx + 1 >= cap) ? 0 : front_idx + 1;
        end else begin
          rear_idx = (rear_idx == 0) ? cap - 1 : rear_idx - 1;
        end
      end
      default: begin
      end
    endcase
    res.ok = done_ok;
    res.front_value = deque_empty ? '1 : slot_store[IDX_W'(front_idx)];
    res.rear_value = deque_empty ? '1 : slot_store[IDX_W'(rear_idx)];
    res.is_empty = deque_empty;
    res.is_full = ring_full(cap);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.front_value, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.ok !== want.ok)
          report_mismatch("ok", DATA_W'(out_data.ok), DATA_W'(want.ok));
        if (out_data.front_value !== want.front_value)
          report_mismatch("front_value", out_data.front_value, want.front_value);
        if (out_data.rear_value !== want.rear_value)
          report_mismatch("rear_value", out_data.rear_value, want.rear_value);
        if (out_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(out_data.is_empty), DATA_W'(want.is_empty));
        if (out_data.is_full !== want.is_full)
          report_mismatch("is_full", DATA_W'(out_data.is_full), DATA_W'(want.is_full));
      end
    end
  end

  // called at a falling edge; returns at a falling edge with start possibly held high
  task automatic send_request(input logic [2:0] code, input logic [DATA_W-1:0] val);
    in_item_t rq;
    rq.req_type = code;
    rq.value = val;
    start = 1'b1;
    in_data = rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(rq));
    requests_sent++;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      in_data.req_type = 3'($urandom);
      in_data.value = $urandom;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = cap;
    @(posedge clk);
    cap_setting = cap;
    front_idx = 0;
    rear_idx = 0;
    deque_empty = 1'b1;
    cap_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = CAP_W'($urandom);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_code(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (roll < 90) return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
    if (roll < 96) return REQ_QUERY;
    return 3'($urandom_range(REQ_CODE_MAX, REQ_QUERY + 3'd1));
  endfunction

  task automatic test_after_reset();
    send_request(REQ_QUERY, '1);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '1);
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h8000_0000);
    send_request(REQ_QUERY, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
  endtask

  task automatic test_unknown_codes();
    send_request(REQ_PUSH_BACK, '1);
    send_request(REQ_QUERY + 3'd1, 32'h5555_5555);
    send_request(REQ_QUERY + 3'd2, 32'hAAAA_AAAA);
    send_request(REQ_CODE_MAX, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_FRONT, '0);
  endtask

  task automatic test_capacity_edges();
    write_capacity('0);
    send_request(REQ_PUSH_FRONT, 32'h1234_5678);
    send_request(REQ_PUSH_BACK, 32'h0BAD_F00D);
    send_request(REQ_POP_BACK, '0);
    write_capacity(CAP_W'(2));
    send_request(REQ_PUSH_FRONT, 32'hCAFE_0001);
    send_request(REQ_PUSH_FRONT, 32'hCAFE_0002);
    send_request(REQ_PUSH_BACK, 32'hCAFE_0003);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
    write_capacity('1);
    send_request(REQ_PUSH_BACK, 32'h0000_0001);
    send_request(REQ_QUERY, '0);
    send_request(REQ_POP_FRONT, '0);
  endtask

  task automatic test_random_mix(input int unsigned gap_pct);
    logic [CAP_W-1:0] caps [9];
    int unsigned push_pct;
    caps = '{CAP_W'(1), CAP_W'(2), CAP_W'(3), CAP_W'(4), CAP_W'(7), CAP_W'(16),
             CAP_W'(0), CAP_W'(1500), CAP_W'(0)};
    caps[8] = CAP_W'($urandom_range(64, 5));
    idle_pct = gap_pct;
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      push_pct = 70;
      for (int n = 0; n < 5; n++) begin
        if (n % 10 == 0) push_pct = $urandom_range(1) ? 70 : 30;
        send_request(pick_code(push_pct), pick_value());
      end
    end
  endtask

  task automatic test_fill_depth();
    idle_pct = 0;
    write_capacity($urandom_range(1) ? CAP_W'(DEPTH) : '1);
    for (int n = 0; n < DEPTH + 2; n++)
      send_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    send_request(REQ_QUERY, '0);
    for (int n = 0; n < 40; n++)
      send_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_value());
    send_request(REQ_QUERY, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    front_idx = 0;
    rear_idx = 0;
    deque_empty = 1'b1;
    cap_setting = CAP_W'(DEPTH);
    err_count = 0;
    requests_sent = 0;
    results_checked = 0;
    cap_writes = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_unknown_codes();
    test_capacity_edges();
    test_random_mix(38);
    test_random_mix(75);
    test_random_mix(0);
    test_fill_depth();
    wait_drained();

    $display("Sent %0d requests across %0d capacity writes; %0d results compared.",
             requests_sent, cap_writes, results_checked);
    $display("Covered all request codes, empty and full edges, wrap-around and a full fill.");
    if (err_count == 0) begin
      $display("circular_deque_ring_buffer verification clean");
    end else begin
      $display("circular_deque_ring_buffer verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("circular_deque_ring_buffer verification failed");
    $finish;
  end

endmodule
